/* design/dual_slot_record_validator_assert.svh */
// ----------------------------------------------------------------------------
// dual slot record validator assertion macros
// concurrent checks sampled on clk and held off while rst is high
// ----------------------------------------------------------------------------
`ifndef DUAL_SLOT_RECORD_VALIDATOR_ASSERT_SVH
`define DUAL_SLOT_RECORD_VALIDATOR_ASSERT_SVH

// condition holds at every edge
`define DSRV_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define DSRV_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/dsrv_pkg.sv */
// ----------------------------------------------------------------------------
// dsrv_pkg
// shared constants, codes, types and the crc16 byte step of the record
// validator
// ----------------------------------------------------------------------------
package dsrv_pkg;

  localparam int PAYLOAD_BYTES = 256;
  localparam int HEADER_BYTES  = 12;
  localparam int HEADER_WORDS  = 5;
  localparam int FORMATS       = 4;
  localparam int POS_W         = $clog2(HEADER_BYTES + PAYLOAD_BYTES + 1);
  localparam int WIDX_W        = $clog2(HEADER_WORDS);
  localparam int CMP_W         = 17;

  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_JUDGE   = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_MAX     = POS_W'(HEADER_BYTES + PAYLOAD_BYTES);
  localparam logic [CMP_W-1:0] CMP_HEADER  = CMP_W'(HEADER_BYTES);
  localparam logic [15:0]      LEN_LIMIT   = 16'(PAYLOAD_BYTES);

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] SEQ_HALF = 16'h8000;

  localparam int WORD_MAGIC    = 0;
  localparam int WORD_VERSION  = 1;
  localparam int WORD_LENGTH   = 2;
  localparam int WORD_SEQUENCE = 3;
  localparam int WORD_CRC      = 4;

  typedef enum logic [2:0] {
    REG_MAGIC       = 3'd0,
    REG_FMT_CURRENT = 3'd1,
    REG_FMT_THIRD   = 3'd2,
    REG_FMT_SECOND  = 3'd3,
    REG_FMT_FIRST   = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    REASON_OK      = 3'd0,
    REASON_MAGIC   = 3'd1,
    REASON_VERSION = 3'd2,
    REASON_LENGTH  = 3'd3,
    REASON_OVER    = 3'd4,
    REASON_CRC     = 3'd5,
    REASON_SHORT   = 3'd6
  } reason_t;

  typedef struct packed {
    logic [15:0]                 magic;
    logic [FORMATS-1:0][31:0]    formats;
  } cfg_t;

  typedef struct packed {
    logic        slot;
    logic        valid;
    reason_t     reason;
    logic [1:0]  fidx;
    logic [15:0] seq;
  } verdict_t;

  typedef struct packed {
    logic any_valid;
    logic newest;
  } choice_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/dsrv_image.sv */
// ----------------------------------------------------------------------------
// dsrv_image
// per-image tracking: header capture, format lookup, payload crc and the
// verdict for the beat that closes an image
// ----------------------------------------------------------------------------
module dsrv_image (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               slot,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  dsrv_pkg::cfg_t     cfg,
  output dsrv_pkg::verdict_t verdict
);

  logic [dsrv_pkg::POS_W-1:0] pos;
  logic [15:0]                hdr [dsrv_pkg::HEADER_WORDS];
  logic [15:0]                crc;
  dsrv_pkg::reason_t          fault;
  logic [1:0]                 hit;

  logic [dsrv_pkg::WIDX_W-1:0] widx;
  logic                        in_header;
  logic                        at_judge;
  logic                        crc_take;
  logic [15:0]                 crc_now;
  logic                        found;
  logic [1:0]                  found_idx;
  logic [15:0]                 fmt_len;
  dsrv_pkg::reason_t           judged;
  logic [1:0]                  judged_hit;
  dsrv_pkg::reason_t           fault_now;
  logic [1:0]                  hit_now;
  dsrv_pkg::verdict_t          v;

  assign widx      = pos[dsrv_pkg::WIDX_W:1];
  assign in_header = pos < dsrv_pkg::POS_PAYLOAD;
  assign at_judge  = pos == dsrv_pkg::POS_JUDGE;

  // first match wins: current, third, second, first
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    fmt_len   = '0;
    for (int i = dsrv_pkg::FORMATS - 1; i >= 0; i--) begin
      if (cfg.formats[i][31:16] == hdr[dsrv_pkg::WORD_VERSION]) begin
        found     = 1'b1;
        found_idx = 2'(i);
        fmt_len   = cfg.formats[i][15:0];
      end
    end
  end

  always_comb begin
    judged_hit = '0;
    if (hdr[dsrv_pkg::WORD_MAGIC] != cfg.magic) begin
      judged = dsrv_pkg::REASON_MAGIC;
    end else if (!found) begin
      judged = dsrv_pkg::REASON_VERSION;
    end else begin
      judged_hit = found_idx;
      if (hdr[dsrv_pkg::WORD_LENGTH] != fmt_len) begin
        judged = dsrv_pkg::REASON_LENGTH;
      end else if (fmt_len > dsrv_pkg::LEN_LIMIT) begin
        judged = dsrv_pkg::REASON_OVER;
      end else begin
        judged = dsrv_pkg::REASON_OK;
      end
    end
  end

  assign fault_now = at_judge ? judged : fault;
  assign hit_now   = at_judge ? judged_hit : hit;

  assign crc_take = !in_header && (fault == dsrv_pkg::REASON_OK) &&
                    (dsrv_pkg::CMP_W'(pos) <
                     dsrv_pkg::CMP_HEADER + dsrv_pkg::CMP_W'(hdr[dsrv_pkg::WORD_LENGTH]));
  assign crc_now  = crc_take ? dsrv_pkg::crc16_byte(crc, data_byte) : crc;

  always_comb begin
    v.slot   = slot;
    v.reason = dsrv_pkg::REASON_OK;
    v.fidx   = '0;
    v.seq    = '0;
    if (pos < dsrv_pkg::POS_JUDGE) begin
      v.reason = dsrv_pkg::REASON_SHORT;
    end else begin
      v.seq = hdr[dsrv_pkg::WORD_SEQUENCE];
      if (fault_now inside {dsrv_pkg::REASON_MAGIC, dsrv_pkg::REASON_VERSION}) begin
        v.reason = fault_now;
      end else begin
        v.fidx = hit_now;
        if (fault_now != dsrv_pkg::REASON_OK) begin
          v.reason = fault_now;
        end else if (dsrv_pkg::CMP_W'(pos) + dsrv_pkg::CMP_W'(1) <
                     dsrv_pkg::CMP_HEADER +
                     dsrv_pkg::CMP_W'(hdr[dsrv_pkg::WORD_LENGTH])) begin
          v.reason = dsrv_pkg::REASON_SHORT;
        end else if (crc_now != hdr[dsrv_pkg::WORD_CRC]) begin
          v.reason = dsrv_pkg::REASON_CRC;
        end
      end
    end
    v.valid = v.reason == dsrv_pkg::REASON_OK;
  end

  assign verdict = v;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      crc   <= dsrv_pkg::CRC_INIT;
      fault <= dsrv_pkg::REASON_OK;
      hit   <= '0;
    end else if (fire) begin
      if (last_byte) begin
        pos   <= '0;
        crc   <= dsrv_pkg::CRC_INIT;
        fault <= dsrv_pkg::REASON_OK;
        hit   <= '0;
      end else begin
        if (pos < dsrv_pkg::POS_MAX) begin
          pos <= pos + 1'b1;
        end
        crc <= crc_now;
        if (at_judge) begin
          fault <= judged;
          hit   <= judged_hit;
        end
      end
    end
  end

  // big-endian words, reserved word dropped
  always_ff @(posedge clk) begin
    if (fire && in_header && widx < dsrv_pkg::WIDX_W'(dsrv_pkg::HEADER_WORDS)) begin
      if (pos[0]) begin
        hdr[widx][7:0] <= data_byte;
      end else begin
        hdr[widx][15:8] <= data_byte;
      end
    end
  end

endmodule

/* design/dsrv_select.sv */
// ----------------------------------------------------------------------------
// dsrv_select
// keeps the latest verdict and sequence of each slot and picks the newer
// valid slot by wrapping sequence compare
// ----------------------------------------------------------------------------
module dsrv_select (
  input  logic               clk,
  input  logic               rst,
  input  logic               update,
  input  dsrv_pkg::verdict_t verdict,
  output dsrv_pkg::choice_t  choice
);

  logic [1:0]  ok;
  logic [15:0] seq [2];

  logic [1:0]  ok_next;
  logic [15:0] seq_next [2];
  logic [15:0] diff;

  always_comb begin
    ok_next     = ok;
    seq_next[0] = seq[0];
    seq_next[1] = seq[1];
    ok_next[verdict.slot]  = verdict.valid;
    seq_next[verdict.slot] = verdict.seq;
  end

  assign diff = seq_next[1] - seq_next[0];

  always_comb begin
    choice.any_valid = |ok_next;
    if (&ok_next) begin
      choice.newest = (diff != 16'h0000) && (diff < dsrv_pkg::SEQ_HALF);
    end else begin
      choice.newest = ok_next[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ok <= '0;
    end else if (update) begin
      ok <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq[0] <= '0;
      seq[1] <= '0;
    end else if (update) begin
      seq[0] <= seq_next[0];
      seq[1] <= seq_next[1];
    end
  end

endmodule

/* design/dual_slot_record_validator.sv */
// ----------------------------------------------------------------------------
// dual_slot_record_validator
// the crc16 step is unrolled; a result registers when the final byte leaves s1
// throughput: one byte per cycle; a final byte waits while the output is full
// reset: synchronous, clears config to zero, crc to 0xffff, both slots invalid
// ----------------------------------------------------------------------------
`include "dual_slot_record_validator_assert.svh"

module dual_slot_record_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        slot,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        checked_slot,
  output logic        slot_valid,
  output logic [2:0]  fail_reason,
  output logic [1:0]  format_index,
  output logic [15:0] record_sequence,
  output logic        any_valid,
  output logic        newest_slot
);

  dsrv_pkg::cfg_t     cfg;
  dsrv_pkg::verdict_t verdict;
  dsrv_pkg::choice_t  choice;

  logic       s1_valid;
  logic       s1_slot;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_fire;
  logic       out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dsrv_pkg::REG_MAGIC:       cfg.magic      <= cfg_data[15:0];
        dsrv_pkg::REG_FMT_CURRENT: cfg.formats[0] <= cfg_data;
        dsrv_pkg::REG_FMT_THIRD:   cfg.formats[1] <= cfg_data;
        dsrv_pkg::REG_FMT_SECOND:  cfg.formats[2] <= cfg_data;
        dsrv_pkg::REG_FMT_FIRST:   cfg.formats[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // a beat without a result never waits on the output side
  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_slot <= slot;
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  dsrv_image u_image (
    .clk       (clk),
    .rst       (rst),
    .fire      (s1_fire),
    .slot      (s1_slot),
    .data_byte (s1_byte),
    .last_byte (s1_last),
    .cfg       (cfg),
    .verdict   (verdict)
  );

  dsrv_select u_select (
    .clk     (clk),
    .rst     (rst),
    .update  (s1_fire && s1_last),
    .verdict (verdict),
    .choice  (choice)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      checked_slot    <= verdict.slot;
      slot_valid      <= verdict.valid;
      fail_reason     <= verdict.reason;
      format_index    <= verdict.fidx;
      record_sequence <= verdict.seq;
      any_valid       <= choice.any_valid;
      newest_slot     <= choice.newest;
    end
  end

  `DSRV_ASSERT_ALWAYS(a_verdict_code, !out_valid || (slot_valid == (fail_reason == dsrv_pkg::REASON_OK)), "slot_valid disagrees with fail_reason")
  `DSRV_ASSERT_IMPLY(a_valid_seen, out_valid && slot_valid, any_valid, "valid slot not counted in any_valid")
  `DSRV_ASSERT_IMPLY(a_no_choice, out_valid && !any_valid, !newest_slot, "newest_slot set with no valid slot")
  `DSRV_ASSERT_IMPLY(a_body_flows, s1_valid && !s1_last, in_ready, "non-final beat stalled the input")

endmodule

/* tb/dsrv_verdict_checker.sv */
// ----------------------------------------------------------------------------
// dsrv_verdict_checker
// Watches the byte and verdict channels of the record validator. It keeps its
// own model of the image state and both slots, builds the expected verdict
// from each accepted byte, and compares every accepted verdict field by field.
// ----------------------------------------------------------------------------
module dsrv_verdict_checker
  import dsrv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        slot,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        checked_slot,
  input  logic        slot_valid,
  input  logic [2:0]  fail_reason,
  input  logic [1:0]  format_index,
  input  logic [15:0] record_sequence,
  input  logic        any_valid,
  input  logic        newest_slot,
  output int          mismatches,
  output int          verdicts_pending,
  output int          verdicts_seen,
  output int          verdicts_passed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        slot;
    logic        ok;
    reason_t     why;
    logic [1:0]  fmt;
    logic [15:0] seq;
    logic        any;
    logic        newest;
  } slot_verdict_t;

  slot_verdict_t verdicts_due[$];
  slot_verdict_t want;

  logic [15:0] magic_cfg;
  logic [31:0] format_cfg [FORMATS];

  int unsigned image_pos;
  logic [15:0] hdr [HEADER_WORDS];
  logic [15:0] crc_acc;
  reason_t     hdr_fault;
  logic [1:0]  fmt_hit;
  logic        slot_ok [2];
  logic [15:0] slot_seq [2];

  // bit-serial form of the ccitt polynomial, msb first
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic clear_image();
    image_pos = 0;
    for (int i = 0; i < HEADER_WORDS; i++) begin
      hdr[i] = 16'h0000;
    end
    crc_acc = CRC_INIT;
    hdr_fault = REASON_OK;
    fmt_hit = 2'd0;
  endtask

  task automatic judge_header();
    logic found;
    logic [15:0] need;
    found = 1'b0;
    need = 16'h0000;
    if (hdr[WORD_MAGIC] != magic_cfg) begin
      hdr_fault = REASON_MAGIC;
    end else begin
      for (int i = 0; i < FORMATS; i++) begin
        if (!found && format_cfg[i][31:16] == hdr[WORD_VERSION]) begin
          found = 1'b1;
          fmt_hit = 2'(i);
          need = format_cfg[i][15:0];
        end
      end
      if (!found) begin
        hdr_fault = REASON_VERSION;
      end else if (hdr[WORD_LENGTH] != need) begin
        hdr_fault = REASON_LENGTH;
      end else if (need > PAYLOAD_BYTES) begin
        hdr_fault = REASON_OVER;
      end
    end
  endtask

  task automatic absorb_byte(input logic s, input logic [7:0] b, input logic l);
    int unsigned p;
    slot_verdict_t v;
    logic [15:0] gap;
    p = image_pos;
    if (p < HEADER_BYTES) begin
      if (p < 2 * HEADER_WORDS) begin
        if (p % 2 == 0) begin
          hdr[p / 2][15:8] = b;
        end else begin
          hdr[p / 2][7:0] = b;
        end
      end
      if (p == HEADER_BYTES - 1) begin
        judge_header();
      end
    end else if (hdr_fault == REASON_OK && p - HEADER_BYTES < hdr[WORD_LENGTH]) begin
      crc_acc = crc_step(crc_acc, b);
    end
    if (p < HEADER_BYTES + PAYLOAD_BYTES) begin
      image_pos = p + 1;
    end
    if (l) begin
      v.slot = s;
      v.fmt = 2'd0;
      v.seq = 16'h0000;
      if (p + 1 < HEADER_BYTES) begin
        v.why = REASON_SHORT;
      end else begin
        v.seq = hdr[WORD_SEQUENCE];
        if (hdr_fault == REASON_MAGIC || hdr_fault == REASON_VERSION) begin
          v.why = hdr_fault;
        end else begin
          v.fmt = fmt_hit;
          if (hdr_fault != REASON_OK) begin
            v.why = hdr_fault;
          end else if (p + 1 < HEADER_BYTES + hdr[WORD_LENGTH]) begin
            v.why = REASON_SHORT;
          end else if (crc_acc != hdr[WORD_CRC]) begin
            v.why = REASON_CRC;
          end else begin
            v.why = REASON_OK;
          end
        end
      end
      v.ok = (v.why == REASON_OK);
      slot_ok[s] = v.ok;
      slot_seq[s] = v.seq;
      v.any = slot_ok[0] || slot_ok[1];
      if (slot_ok[0] && slot_ok[1]) begin
        gap = slot_seq[1] - slot_seq[0];
        v.newest = (gap != 16'h0000) && (gap < SEQ_HALF);
      end else begin
        v.newest = slot_ok[1];
      end
      verdicts_due.push_back(v);
      clear_image();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    if (mismatches < 60) begin
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, exp_val);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      verdicts_due.delete();
      mismatches = 0;
      verdicts_seen = 0;
      verdicts_passed = 0;
      magic_cfg = 16'h0000;
      for (int i = 0; i < FORMATS; i++) begin
        format_cfg[i] = 32'h0;
      end
      for (int i = 0; i < 2; i++) begin
        slot_ok[i] = 1'b0;
        slot_seq[i] = 16'h0000;
      end
      clear_image();
    end else begin
      if (cfg_we) begin
        if (reg_index_t'(cfg_index) == REG_MAGIC) begin
          magic_cfg = cfg_data[15:0];
        end else if (cfg_index <= REG_FMT_FIRST) begin
          format_cfg[cfg_index - 1] = cfg_data;
        end
      end
      // verdict beat
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (slot_valid === 1'b1) begin
          verdicts_passed++;
        end
        if (verdicts_due.size() == 0) begin
          report_mismatch("verdict with none pending", checked_slot, 16'h0);
        end else begin
          want = verdicts_due.pop_front();
          if (checked_slot !== want.slot) begin
            report_mismatch("checked_slot", checked_slot, want.slot);
          end
          if (slot_valid !== want.ok) begin
            report_mismatch("slot_valid", slot_valid, want.ok);
          end
          if (fail_reason !== want.why) begin
            report_mismatch("fail_reason", fail_reason, want.why);
          end
          if (format_index !== want.fmt) begin
            report_mismatch("format_index", format_index, want.fmt);
          end
          if (record_sequence !== want.seq) begin
            report_mismatch("record_sequence", record_sequence, want.seq);
          end
          if (any_valid !== want.any) begin
            report_mismatch("any_valid", any_valid, want.any);
          end
          if (newest_slot !== want.newest) begin
            report_mismatch("newest_slot", newest_slot, want.newest);
          end
        end
      end
      // byte beat
      if (in_valid && in_ready) begin
        absorb_byte(slot, data_byte, last_byte);
      end
    end
    verdicts_pending = verdicts_due.size();
  end

endmodule

/* tb/dual_slot_record_validator_tb.sv */
// ----------------------------------------------------------------------------
// dual_slot_record_validator_tb
// Streams record images into the validator under three register settings:
// a short directed set, then random records that are mostly well formed,
// with corrupted, cut, padded and noisy images mixed in. Sender and receiver
// idle at random in the first two settings; one long hold-off backs it up.
// ----------------------------------------------------------------------------
module dual_slot_record_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dsrv_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BEATS = 520;

  localparam logic [15:0] MAGIC_SET [3] = '{16'hA55A, 16'hFFFF, 16'h0000};
  localparam logic [31:0] FMT_SET [3][4] = '{
    '{32'h0005_0014, 32'h0004_0000, 32'h0002_012C, 32'h0004_0007},
    '{32'hFFFF_0100, 32'h0000_0001, 32'h8000_FFFF, 32'h1234_0028},
    '{32'h0001_0005, 32'h0001_0009, 32'h7FFF_000C, 32'hFFFE_0040}
  };

  typedef enum int {
    REC_GOOD,
    REC_BAD_CRC,
    REC_CUT_PAYLOAD,
    REC_TAIL,
    REC_LONG_TAIL,
    REC_BAD_MAGIC,
    REC_BAD_VERSION,
    REC_BAD_LENGTH,
    REC_CUT_HEADER,
    REC_NOISE
  } rec_kind_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        slot;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        checked_slot;
  logic        slot_valid;
  logic [2:0]  fail_reason;
  logic [1:0]  format_index;
  logic [15:0] record_sequence;
  logic        any_valid;
  logic        newest_slot;

  int mismatches;
  int verdicts_pending;
  int verdicts_seen;
  int verdicts_passed;

  int          send_idle;
  int          recv_idle;
  logic        hold_req;
  int          beats_sent;
  int          quiet_cycles;
  logic [15:0] last_seq;
  logic [15:0] cur_magic;
  logic [31:0] cur_fmt [4];

  dual_slot_record_validator u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .slot            (slot),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .checked_slot    (checked_slot),
    .slot_valid      (slot_valid),
    .fail_reason     (fail_reason),
    .format_index    (format_index),
    .record_sequence (record_sequence),
    .any_valid       (any_valid),
    .newest_slot     (newest_slot)
  );

  dsrv_verdict_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .slot             (slot),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .checked_slot     (checked_slot),
    .slot_valid       (slot_valid),
    .fail_reason      (fail_reason),
    .format_index     (format_index),
    .record_sequence  (record_sequence),
    .any_valid        (any_valid),
    .newest_slot      (newest_slot),
    .mismatches       (mismatches),
    .verdicts_pending (verdicts_pending),
    .verdicts_seen    (verdicts_seen),
    .verdicts_passed  (verdicts_passed)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #5 clk = ~clk;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_settings(input int ph);
    cur_magic = MAGIC_SET[ph];
    write_reg(REG_MAGIC, {16'h0000, MAGIC_SET[ph]});
    for (int i = 0; i < 4; i++) begin
      cur_fmt[i] = FMT_SET[ph][i];
      write_reg(reg_index_t'(i + 1), FMT_SET[ph][i]);
    end
  endtask

  // returns at the accepting edge; valid stays up until the next falling edge
  task automatic send_beat(input logic s, input logic [7:0] b, input logic l);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    slot = s;
    data_byte = b;
    last_byte = l;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_record(input int fmt, input rec_kind_t kind);
    logic [7:0]  image [$];
    logic [7:0]  payload [$];
    logic [15:0] words [6];
    logic [15:0] ver;
    logic [15:0] len;
    logic [15:0] crc;
    logic        s;
    logic        hit;
    int          plen;
    int          total;
    int          flip_at;
    ver = cur_fmt[fmt][31:16];
    len = cur_fmt[fmt][15:0];
    plen = (len > PAYLOAD_BYTES) ? $urandom_range(4) : len;
    case ($urandom_range(8))
      4: last_seq = last_seq;
      5: last_seq = last_seq + 16'h0001;
      6: last_seq = last_seq - 16'h0001;
      7: last_seq = last_seq + 16'h8000;
      8: last_seq = last_seq + 16'h7FFF;
      default: last_seq = 16'($urandom);
    endcase
    crc = CRC_INIT;
    for (int i = 0; i < plen; i++) begin
      payload.push_back(8'($urandom));
      crc = crc16_byte(crc, payload[i]);
    end
    words[WORD_MAGIC] = cur_magic;
    words[WORD_VERSION] = ver;
    words[WORD_LENGTH] = len;
    words[WORD_SEQUENCE] = last_seq;
    words[WORD_CRC] = crc;
    words[5] = 16'($urandom);
    case (kind)
      REC_BAD_CRC: words[WORD_CRC] = crc ^ 16'($urandom_range(1, 65535));
      REC_BAD_MAGIC: words[WORD_MAGIC] = cur_magic ^ 16'($urandom_range(1, 65535));
      REC_BAD_LENGTH: words[WORD_LENGTH] = len ^ 16'($urandom_range(1, 65535));
      REC_BAD_VERSION: begin
        do begin
          words[WORD_VERSION] = 16'($urandom);
          hit = 1'b0;
          for (int i = 0; i < 4; i++) begin
            hit = hit | (cur_fmt[i][31:16] == words[WORD_VERSION]);
          end
        end while (hit);
      end
      default: ;
    endcase
    for (int i = 0; i < 6; i++) begin
      image.push_back(words[i][15:8]);
      image.push_back(words[i][7:0]);
    end
    for (int i = 0; i < plen; i++) begin
      image.push_back(payload[i]);
    end
    case (kind)
      REC_CUT_HEADER: total = $urandom_range(1, HEADER_BYTES - 1);
      REC_CUT_PAYLOAD: total = HEADER_BYTES + ((plen > 0) ? $urandom_range(0, plen - 1) : 0);
      REC_TAIL: total = HEADER_BYTES + plen + $urandom_range(1, 6);
      REC_LONG_TAIL: total = HEADER_BYTES + PAYLOAD_BYTES + $urandom_range(1, 6);
      REC_NOISE: total = $urandom_range(1, 30);
      default: total = HEADER_BYTES + plen;
    endcase
    if (kind == REC_NOISE) begin
      image.delete();
    end
    while (image.size() < total) begin
      image.push_back(8'($urandom));
    end
    s = 1'($urandom_range(1));
    flip_at = ($urandom_range(99) < 6) ? $urandom_range(total - 1) : total;
    for (int i = 0; i < total; i++) begin
      send_beat((i >= flip_at) ? ~s : s, image[i], i == total - 1);
    end
  endtask

  task automatic send_random_record();
    rec_kind_t kind;
    int        r;
    int        f;
    r = $urandom_range(99);
    if (r < 50) kind = REC_GOOD;
    else if (r < 60) kind = REC_BAD_CRC;
    else if (r < 68) kind = REC_CUT_PAYLOAD;
    else if (r < 76) kind = REC_TAIL;
    else if (r < 81) kind = REC_BAD_MAGIC;
    else if (r < 86) kind = REC_BAD_VERSION;
    else if (r < 91) kind = REC_BAD_LENGTH;
    else if (r < 96) kind = REC_CUT_HEADER;
    else kind = REC_NOISE;
    f = $urandom_range(3);
    // keep long payloads rare
    if (cur_fmt[f][15:0] > 64 && cur_fmt[f][15:0] <= PAYLOAD_BYTES && $urandom_range(99) < 80) begin
      f = $urandom_range(3);
    end
    send_record(f, kind);
  endtask

  // receiver side
  initial begin
    logic hold_taken;
    out_ready = 1'b0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no beat for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MAGIC;
    cfg_data = 32'h0;
    in_valid = 1'b0;
    slot = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    hold_req = 1'b0;
    send_idle = 33;
    recv_idle = 49;
    beats_sent = 0;
    last_seq = 16'h0000;
    cur_magic = 16'h0000;
    for (int i = 0; i < 4; i++) begin
      cur_fmt[i] = 32'h0;
    end
    repeat (6) @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      while (verdicts_pending != 0) @(negedge clk);
      repeat (4) @(negedge clk);
      load_settings(ph);
      case (ph)
        0: begin
          send_idle = 33;
          recv_idle = 49;
        end
        1: begin
          send_idle = 49;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (ph == 0) begin
        // one-byte image, a zero-length record on a duplicated version,
        // and a record whose format is longer than the payload limit
        send_beat(1'b1, 8'hFF, 1'b1);
        send_record(1, REC_GOOD);
        send_record(2, REC_GOOD);
      end
      if (ph == 1) begin
        send_record(3, REC_LONG_TAIL);
      end
      if (ph == 2) begin
        hold_req <= 1'b1;
        repeat (40) send_record(0, REC_CUT_HEADER);
      end
      while (beats_sent < (ph + 1) * PHASE_BEATS) begin
        send_random_record();
      end
      stop_sending();
    end

    while (verdicts_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("run covered %0d byte beats under three register settings, %0d verdicts (%0d valid)",
             beats_sent, verdicts_seen, verdicts_passed);
    $display("with cut, padded, corrupted and noisy images and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && verdicts_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
